@@ design/strm_pkg.sv @@
// ----------------------------------------------------------------------------
// strm_pkg: shared types and constants for the range-maximum tree
// Holds field widths, the tree level record and the operation codes.
// ----------------------------------------------------------------------------
package strm_pkg;

  localparam int ValueWidth = 31;
  localparam int PosWidth   = 19;

  localparam logic ActSet   = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Walk record handed from one level cell to the next
  typedef struct packed {
    logic                  active;
    logic                  is_query;
    logic [20:0]           a;
    logic [20:0]           b;
    logic [ValueWidth-1:0] best;
    logic [ValueWidth-1:0] carry;
  } walk_t;

endpackage

@@ design/segment_tree_range_max_top.sv @@
// ----------------------------------------------------------------------------
// segment_tree_range_max_top: segment tree of range maxima
// A row of level cells, leaves first, one node level per cell.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | content
// s_axis  | in  | s_axis_tvalid/tready  | action, position, value, low, high
// m_axis  | out | m_axis_tvalid/tready  | max_value
// cfg     | in  | cfg_valid/cfg_ready   | element_count
// Each level cell registers its node reads and the walk record, then folds
// them; the last cell feeds the root cell, whose result is registered.
// One item is in flight: a set frees the input once its walk leaves the last
// cell, a query once its result is taken; a set outside the count is dropped
// and frees the input the next cycle.
// Reset and a count write run a clearing pass over every node address,
// stalling both inputs. A waiting result stalls input until it is taken.
// ----------------------------------------------------------------------------
module segment_tree_range_max_top #(
  parameter int LEAVES = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[0], position[19:1], new_value[50:20], range_low[69:51],
  // range_high[88:70], zero fill [95:89]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // max_value[30:0], zero fill [31]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [18:0] cfg_data
);
  import strm_pkg::*;

  localparam int Levels = (LEAVES > 1) ? $clog2(LEAVES) : 1;

  walk_t              chain [Levels+1];
  walk_t              launch;
  logic               busy, clearing;
  logic [Levels-1:0]  clr_addr;
  logic [19:0]        count;
  logic [19:0]        cnt_next, lo, hi, pos;
  logic [ValueWidth-1:0] res;
  logic               act;
  logic [ValueWidth-1:0] root, root_best;

  assign act = s_axis_tdata[0];
  assign pos = {1'b0, s_axis_tdata[19:1]};
  assign lo  = (s_axis_tdata[69:51] == 19'd0) ? 20'd1 : {1'b0, s_axis_tdata[69:51]};
  assign hi  = ({1'b0, s_axis_tdata[88:70]} > count) ? count : {1'b0, s_axis_tdata[88:70]};

  assign s_axis_tready = !busy && !m_axis_tvalid && !clearing && !cfg_valid;
  assign cfg_ready     = !busy && !clearing;
  assign m_axis_tdata  = {1'b0, res};

  // Clamp a written count
  always_comb begin
    cnt_next = {1'b0, cfg_data};
    if (cnt_next == 20'd0) cnt_next = 20'd1;
    if ({1'b0, cnt_next} > 21'(LEAVES)) cnt_next = 20'(LEAVES);
  end

  // Launch an item into the leaf cell
  always_comb begin
    launch = '0;
    launch.active   = s_axis_tvalid && s_axis_tready &&
                      (act == ActQuery || (pos != 20'd0 && pos <= count));
    launch.is_query = (act == ActQuery);
    launch.carry    = s_axis_tdata[50:20];
    if (act == ActQuery) begin
      launch.a = (lo <= hi) ? 21'(lo - 20'd1) : 21'd0;
      launch.b = (lo <= hi) ? 21'(hi) : 21'd0;
    end else begin
      launch.a = 21'(pos - 20'd1);
      launch.b = 21'(pos - 20'd1);
    end
  end

  assign chain[0] = launch;

  genvar g;
  generate
    for (g = 0; g < Levels; g++) begin : gen_lvl
      localparam int Bits = (Levels - g < 1) ? 1 : Levels - g;
      strm_level #(.IdxBits(Bits), .Depth(1 << Bits)) u_lvl (
        .clk, .rst, .clear_en(clearing), .clear_addr(clr_addr[Bits-1:0]),
        .walk_in(chain[g]), .walk_out(chain[g+1]));
    end
  endgenerate

  // Root cell: a query whose span still holds the root folds it in
  always_comb begin
    root_best = chain[Levels].best;
    if (chain[Levels].a < chain[Levels].b && root > root_best) root_best = root;
  end

  // Control: clearing pass, busy flag, count, root and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      count         <= 20'd1;
      root          <= '0;
      res           <= '0;
      clearing      <= 1'b1;
      clr_addr      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count    <= cnt_next;
        clearing <= 1'b1;
        clr_addr <= '0;
      end else if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) clearing <= 1'b0;
      end
      if (cfg_valid && cfg_ready) root <= '0;
      else if (chain[Levels].active && !chain[Levels].is_query) root <= chain[Levels].carry;
      if (chain[0].active) busy <= 1'b1;
      else if (chain[Levels].active) busy <= 1'b0;
      if (chain[Levels].active && chain[Levels].is_query) begin
        m_axis_tvalid <= 1'b1;
        res           <= root_best;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    chain[Levels].active |-> busy) else $error("level walk without owner");
  a_no_launch: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("launch while busy");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready && !cfg_ready) else $error("input during clearing");

endmodule

@@ design/strm_level.sv @@
// ----------------------------------------------------------------------------
// strm_level: one tree level
// Holds the node maxima of one level. The node reads are registered with
// the walk record; then a set walk carries the parent maximum up and a
// query walk folds in the edge nodes of its span.
// ----------------------------------------------------------------------------
module strm_level #(
  parameter int IdxBits = 1,
  parameter int Depth   = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear_en,
  input  logic [IdxBits-1:0] clear_addr,
  input  strm_pkg::walk_t    walk_in,
  output strm_pkg::walk_t    walk_out
);
  import strm_pkg::*;

  logic [ValueWidth-1:0] node_mem [Depth];
  logic [IdxBits-1:0]    ia, ib, sib, rd_addr;
  logic [ValueWidth-1:0] rd_a, rd_b, best_next, mx;
  walk_t                 held, nxt;

  assign ia      = walk_in.a[IdxBits-1:0];
  assign ib      = walk_in.b[IdxBits-1:0] - IdxBits'(1);
  assign sib     = ia ^ IdxBits'(1);
  assign rd_addr = walk_in.is_query ? ib : sib;

  // Clear one entry per cycle during a pass, write set walks, read two nodes
  always_ff @(posedge clk) begin
    if (clear_en) begin
      node_mem[clear_addr] <= '0;
    end else if (walk_in.active && !walk_in.is_query) begin
      node_mem[ia] <= walk_in.carry;
    end
    rd_a <= node_mem[ia];
    rd_b <= node_mem[rd_addr];
  end

  // Fold the span edges into the running best, form the parent maximum
  always_comb begin
    best_next = held.best;
    if (held.a < held.b) begin
      if (held.a[0] && rd_a > best_next) best_next = rd_a;
      if (held.b[0] && rd_b > best_next) best_next = rd_b;
    end
    mx = (rd_b > held.carry) ? rd_b : held.carry;
  end

  // Move the span or the set index to the parent level
  always_comb begin
    nxt       = held;
    nxt.a     = held.is_query ? (held.a + {20'd0, held.a[0]}) >> 1 : held.a >> 1;
    nxt.b     = held.b >> 1;
    nxt.best  = best_next;
    nxt.carry = mx;
  end

  // Hold the record while the reads complete, then advance it
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      walk_out <= '0;
    end else begin
      held     <= walk_in;
      walk_out <= nxt;
    end
  end

endmodule

@@ tb/sv/segment_tree_range_max_top_tb.sv @@
// ----------------------------------------------------------------------------
// segment_tree_range_max_top_tb: self-checking bench for the range-max tree
// Drives set and query items over the stream port, rewrites the element count
// between phases, and checks every result against a sparse local tree model.
// ----------------------------------------------------------------------------
module segment_tree_range_max_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import strm_pkg::*;

  localparam int LEAVES   = 262144;
  localparam int LATENCY  = 40;
  localparam int CYC_MAX  = 10000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [18:0] cfg_data = '0;

  segment_tree_range_max_top #(.LEAVES(LEAVES)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Sparse tree of maxima, absent nodes read as zero
  logic [ValueWidth-1:0] tree_max [int];
  int unsigned           count_in_use;
  logic [ValueWidth-1:0] pending_max [$];

  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  function automatic logic [ValueWidth-1:0] node_at(int i);
    return tree_max.exists(i) ? tree_max[i] : '0;
  endfunction

  function automatic logic [ValueWidth-1:0] bigger(logic [ValueWidth-1:0] x,
                                                   logic [ValueWidth-1:0] y);
    return x > y ? x : y;
  endfunction

  // Rewrite a count: clamp and clear the tree
  function automatic void apply_count(logic [18:0] v);
    int unsigned c;
    c = v;
    if (c < 1) c = 1;
    if (c > LEAVES) c = LEAVES;
    count_in_use = c;
    tree_max.delete();
  endfunction

  // Work out the effect of one accepted item
  function automatic void predict_item(logic [95:0] d);
    int unsigned pos, lo, hi, a, b, i;
    logic [ValueWidth-1:0] best;
    if (d[0] == ActSet) begin
      pos = d[19:1];
      if (pos >= 1 && pos <= count_in_use) begin
        i = pos - 1 + LEAVES;
        tree_max[i] = d[50:20];
        i = i >> 1;
        while (i >= 1) begin
          tree_max[i] = bigger(node_at(2*i), node_at(2*i+1));
          i = i >> 1;
        end
      end
    end else begin
      lo = d[69:51];
      hi = d[88:70];
      best = '0;
      if (lo < 1) lo = 1;
      if (hi > count_in_use) hi = count_in_use;
      if (lo <= hi) begin
        a = lo - 1 + LEAVES;
        b = hi + LEAVES;
        while (a < b) begin
          if (a[0]) begin
            best = bigger(best, node_at(a));
            a++;
          end
          if (b[0]) begin
            b--;
            best = bigger(best, node_at(b));
          end
          a = a >> 1;
          b = b >> 1;
        end
      end
      pending_max.push_back(best);
    end
  endfunction

  function automatic logic [95:0] pack_item(logic act, logic [18:0] pos,
                                            logic [30:0] val, logic [18:0] lo,
                                            logic [18:0] hi);
    return {7'd0, hi, lo, val, pos, act};
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall, check against oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_max.size() == 0) begin
          $error("max_value: no result expected, actual %0d", m_axis_tdata[30:0]);
          errors++;
        end else begin
          if (m_axis_tdata[30:0] !== pending_max[0] || m_axis_tdata[31] !== 1'b0) begin
            $error("max_value: expected %0d, actual %0d", pending_max[0],
                   m_axis_tdata);
            errors++;
          end
          void'(pending_max.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one item; valid stays up until the next item or a drain
  task automatic send_item(logic [95:0] d);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(d);
  endtask

  // Wait for every result, then let the pipe drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_count(logic [18:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_count(v);
  endtask

  // Random phase: mostly sets and queries within range, some outside
  task automatic random_items(int n);
    int unsigned c, lo, hi;
    logic [18:0] p;
    logic [30:0] v;
    for (int k = 0; k < n; k++) begin
      c = count_in_use;
      p = ($urandom_range(9) == 0) ? 19'($urandom) : 19'($urandom_range(c + 1, 0));
      case ($urandom_range(3))
        0: v = 31'($urandom);
        1: v = 31'h7fffffff - 31'($urandom_range(3));
        default: v = 31'($urandom_range(1000));
      endcase
      lo = $urandom_range(c + 1, 0);
      hi = $urandom_range(c + 1, 0);
      if ($urandom_range(3) != 0 && lo > hi) begin
        lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
      end
      if ($urandom_range(9) == 0) begin
        lo = $urandom; lo = lo & 19'h7ffff;
        hi = $urandom; hi = hi & 19'h7ffff;
      end
      send_item(pack_item(logic'($urandom_range(1)), p, v, 19'(lo), 19'(hi)));
    end
  endtask

  typedef struct {
    logic        act;
    logic [18:0] pos;
    logic [30:0] val;
    logic [18:0] lo;
    logic [18:0] hi;
    logic        known;
    logic [30:0] want;
  } step_row_t;

  step_row_t directed [] = '{
    '{ActQuery, 19'd0, 31'd0, 19'd1, 19'd1, 1'b1, 31'd0},
    '{ActSet,   19'd1, 31'h7fffffff, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActQuery, 19'd0, 31'd0, 19'd1, 19'd1, 1'b1, 31'h7fffffff},
    '{ActSet,   19'd2, 31'd5, 19'h7ffff, 19'h7ffff, 1'b0, 31'd0},
    '{ActSet,   19'd0, 31'd9, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActQuery, 19'h7ffff, 31'h7fffffff, 19'd0, 19'h7ffff, 1'b1, 31'h7fffffff},
    '{ActQuery, 19'd0, 31'd0, 19'd2, 19'd1, 1'b1, 31'd0},
    '{ActQuery, 19'd0, 31'd0, 19'd2, 19'h7ffff, 1'b1, 31'd0},
    '{ActSet,   19'd1, 31'd0, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActQuery, 19'd0, 31'd0, 19'd1, 19'd1, 1'b1, 31'd0}
  };

  step_row_t wide_rows [] = '{
    '{ActSet,   19'd262144, 31'd77, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActSet,   19'd1, 31'd12, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActSet,   19'd131072, 31'd40, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActSet,   19'd262145, 31'd999, 19'd0, 19'd0, 1'b0, 31'd0},
    '{ActQuery, 19'd0, 31'd0, 19'd1, 19'd262144, 1'b1, 31'd77},
    '{ActQuery, 19'd0, 31'd0, 19'd1, 19'd131071, 1'b1, 31'd12},
    '{ActQuery, 19'd0, 31'd0, 19'd2, 19'd262143, 1'b0, 31'd0},
    '{ActQuery, 19'd0, 31'd0, 19'd262144, 19'h7ffff, 1'b1, 31'd77},
    '{ActQuery, 19'd0, 31'd0, 19'd262145, 19'h7ffff, 1'b1, 31'd0}
  };

  task automatic run_rows(step_row_t rows []);
    foreach (rows[r]) begin
      send_item(pack_item(rows[r].act, rows[r].pos, rows[r].val, rows[r].lo,
                          rows[r].hi));
      if (rows[r].known && pending_max.size() != 0 &&
          pending_max[$] !== rows[r].want) begin
        $error("max_value: table row %0d expected %0d, model %0d", r,
               rows[r].want, pending_max[$]);
        errors++;
      end
    end
  endtask

  initial begin
    apply_count(19'd1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: count after reset, a written zero count (clamped to one), then widest count
    run_rows(directed);
    write_count(19'd0);
    run_rows(directed);
    write_count(19'h7ffff);
    run_rows(wide_rows);

    // Random phases over several counts and idling mixes
    src_idle_pct = 15; snk_idle_pct = 78;
    write_count(19'd16);
    random_items(220);
    src_idle_pct = 78; snk_idle_pct = 15;
    write_count(19'd1);
    random_items(60);
    write_count(19'd1000);
    random_items(160);
    src_idle_pct = 0; snk_idle_pct = 0;
    write_count(19'd262144);
    random_items(80);
    write_count(19'd7);
    random_items(130);

    // Drain with a bound
    s_axis_tvalid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
